>>> hdl/fwa_pkg.sv
// Package for the flash write aligner: codes, command word and shared constants.
`default_nettype none

package fwa_pkg;

  localparam int unsigned BLOCK_BYTES_DEF = 8;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam logic [31:0] FLASH_SIZE_RST  = 32'd1048576;

  localparam int unsigned IN_TDATA_W  = 104;
  localparam int unsigned OUT_TDATA_W = 104;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_FLUSH = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_CONTIG = 2'd1,
    ST_MISALIGNED = 2'd2,
    ST_BEYOND     = 2'd3
  } status_e;

  // classified command handed from front to back
  typedef struct packed {
    opcode_e     op;
    logic [7:0]  data_byte;
    logic [31:0] byte_address;
    logic [31:0] range_start;
    logic [31:0] range_end;
    logic        aligned;   // byte_address is a block boundary
    logic        beyond;    // a block starting here would run past the flash
  } cmd_t;

endpackage

`default_nettype wire

>>> hdl/fwa_front.sv
// Front end: takes input words, checks alignment and flash bound, pushes commands.
`default_nettype none

module fwa_front #(
  parameter int unsigned BLOCK_BYTES = fwa_pkg::BLOCK_BYTES_DEF
) (
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [1:0]   opcode_i,
  input  logic [7:0]   data_byte_i,
  input  logic [31:0]  byte_address_i,
  input  logic [31:0]  range_start_i,
  input  logic [31:0]  range_end_i,
  input  logic [31:0]  flash_size_i,
  input  logic         full_i,
  output logic         push_o,
  output fwa_pkg::cmd_t cmd_o
);
  import fwa_pkg::*;

  typedef logic [2:0] weight_arr_t [8];
  typedef logic [2:0] mod_tab_t [256];

  // residue of 16**k modulo the block size
  function automatic weight_arr_t build_weights();
    weight_arr_t w;
    int unsigned r;
    r = 1 % BLOCK_BYTES;
    for (int k = 0; k < 8; k++) begin
      w[k] = 3'(r);
      r = (r * 16) % BLOCK_BYTES;
    end
    return w;
  endfunction

  function automatic mod_tab_t build_mod_tab();
    mod_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = 3'(i % BLOCK_BYTES);
    end
    return t;
  endfunction

  localparam weight_arr_t W       = build_weights();
  localparam mod_tab_t    MOD_TAB = build_mod_tab();

  logic [9:0]  fold1;
  logic [7:0]  fold2;
  logic [32:0] blk_end;

  // residue folding: nibbles weighted by 16**k mod block size, twice, then a table
  always_comb begin
    fold1 = '0;
    for (int k = 0; k < 8; k++) begin
      fold1 = fold1 + 10'(byte_address_i[4*k +: 4] * W[k]);
    end
    fold2 = 8'(fold1[3:0] * W[0]) + 8'(fold1[7:4] * W[1]) + 8'(fold1[9:8] * W[2]);
  end

  assign blk_end = {1'b0, byte_address_i} + 33'(BLOCK_BYTES);

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i && (opcode_e'(opcode_i) != OP_NONE);

  always_comb begin
    cmd_o.op           = opcode_e'(opcode_i);
    cmd_o.data_byte    = data_byte_i;
    cmd_o.byte_address = byte_address_i;
    cmd_o.range_start  = range_start_i;
    cmd_o.range_end    = range_end_i;
    cmd_o.aligned      = (MOD_TAB[fold2] == 3'd0);
    cmd_o.beyond       = blk_end > {1'b0, flash_size_i};
  end

endmodule

`default_nettype wire

>>> hdl/fwa_queue.sv
// Short command queue between front and back.
`default_nettype none

module fwa_queue #(
  parameter int unsigned DEPTH = fwa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  fwa_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output fwa_pkg::cmd_t cmd_o,
  output logic          empty_o,
  output logic          full_o
);
  import fwa_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/fwa_back.sv
// Back end: gather state, block assembly, overlap check and output register.
`default_nettype none

module fwa_back #(
  parameter int unsigned BLOCK_BYTES = fwa_pkg::BLOCK_BYTES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  fwa_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          is_block_write_o,
  output logic [31:0]   write_address_o,
  output logic [63:0]   block_data_o,
  output logic [1:0]    status_o,
  output logic          overlaps_o
);
  import fwa_pkg::*;

  localparam int unsigned FILL_W = $clog2(BLOCK_BYTES + 1);
  localparam int unsigned IDX_W  = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;

  logic [7:0]        gather_q [BLOCK_BYTES];
  logic [FILL_W-1:0] fill_q, fill_d, fill_inc;
  logic [31:0]       next_q, next_d;
  logic [31:0]       start_q, start_d;
  logic              known_q, known_d;

  logic              out_valid_q, out_valid_d;
  logic              out_blk_q, out_blk_d;
  logic [31:0]       out_addr_q, out_addr_d;
  logic [63:0]       out_data_q, out_data_d;
  status_e           out_status_q, out_status_d;
  logic              out_ov_q, out_ov_d;

  logic              out_free, exec, gather_we, take_new;
  logic [63:0]       packed_blk;

  assign out_free = !out_valid_q || out_ready_i;
  assign exec     = valid_i && out_free;
  assign pop_o    = exec;
  assign fill_inc = fill_q + FILL_W'(1);

  // block image: gathered bytes below fill, optionally the incoming byte at fill
  always_comb begin
    packed_blk = '0;
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      if (FILL_W'(i) < fill_q) begin
        packed_blk[8*i +: 8] = gather_q[i];
      end else if (take_new && FILL_W'(i) == fill_q) begin
        packed_blk[8*i +: 8] = cmd_i.data_byte;
      end
    end
  end

  always_comb begin
    fill_d       = fill_q;
    next_d       = next_q;
    start_d      = start_q;
    known_d      = known_q;
    gather_we    = 1'b0;
    take_new     = 1'b0;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_blk_d    = out_blk_q;
    out_addr_d   = out_addr_q;
    out_data_d   = out_data_q;
    out_status_d = out_status_q;
    out_ov_d     = out_ov_q;

    if (exec) begin
      unique case (cmd_i.op)
        OP_WRITE: begin
          out_blk_d  = 1'b0;
          out_addr_d = '0;
          out_data_d = '0;
          out_ov_d   = 1'b0;
          priority if (fill_q != '0 && (!known_q || cmd_i.byte_address != next_q)) begin
            out_valid_d  = 1'b1;
            out_status_d = ST_NOT_CONTIG;
          end else if (fill_q == '0 && !(known_q && cmd_i.byte_address == next_q)
                       && !cmd_i.aligned) begin
            out_valid_d  = 1'b1;
            out_status_d = ST_MISALIGNED;
          end else if (fill_q == '0 && cmd_i.beyond) begin
            out_valid_d  = 1'b1;
            out_status_d = ST_BEYOND;
          end else begin
            gather_we = 1'b1;
            take_new  = 1'b1;
            next_d    = cmd_i.byte_address + 32'd1;
            known_d   = 1'b1;
            if (fill_q == '0) begin
              start_d = cmd_i.byte_address;
            end
            if (fill_inc == FILL_W'(BLOCK_BYTES)) begin
              fill_d       = '0;
              out_valid_d  = 1'b1;
              out_blk_d    = 1'b1;
              out_addr_d   = (fill_q == '0) ? cmd_i.byte_address : start_q;
              out_data_d   = packed_blk;
              out_status_d = ST_OK;
            end else begin
              fill_d = fill_inc;
            end
          end
        end
        OP_FLUSH: begin
          if (fill_q != '0) begin
            fill_d       = '0;
            known_d      = 1'b0;
            out_valid_d  = 1'b1;
            out_blk_d    = 1'b1;
            out_addr_d   = start_q;
            out_data_d   = packed_blk;
            out_status_d = ST_OK;
            out_ov_d     = 1'b0;
          end
        end
        OP_QUERY: begin
          out_valid_d  = 1'b1;
          out_blk_d    = 1'b0;
          out_addr_d   = '0;
          out_data_d   = '0;
          out_status_d = ST_OK;
          out_ov_d     = (fill_q != '0) && (cmd_i.range_start < next_q)
                         && (cmd_i.range_end > start_q);
        end
        default: begin
          // unused opcode is filtered out by the front end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (gather_we) begin
      gather_q[fill_q[IDX_W-1:0]] <= cmd_i.data_byte;
    end
    out_blk_q    <= out_blk_d;
    out_addr_q   <= out_addr_d;
    out_data_q   <= out_data_d;
    out_status_q <= out_status_d;
    out_ov_q     <= out_ov_d;
    start_q      <= start_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      next_q      <= '0;
      known_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      next_q      <= next_d;
      known_q     <= known_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign is_block_write_o = out_blk_q;
  assign write_address_o  = out_addr_q;
  assign block_data_o     = out_data_q;
  assign status_o         = out_status_q;
  assign overlaps_o       = out_ov_q;

endmodule

`default_nettype wire

>>> hdl/flash_write_aligner_unit.sv
// Top level of the flash write aligner: config register, front, queue and back.
//
// Usage: a stream of flash commands enters on the s_axis group, one word per
// command (tuser = opcode: write byte, flush, overlap query). Writes are gathered
// into aligned blocks; each full or flushed block leaves on m_axis with
// tuser = 1 and its start address. Queries and rule violations give one word
// with tuser = 0 carrying status and the overlap answer. Writes into a partly
// filled block give no word.
// The flash size register is written through cfg_we_i / cfg_wdata_i while idle.
// Throughput: one command per cycle while the receiver does not stall. The front
// checks alignment and the flash bound and pushes into a two-entry queue; the
// back executes one command a cycle, when its output register is free, against
// the fill count and end-address register, and registers each result there.
// Reset: fill count, tracked end address and queue clear at once, flash size
// returns to 1 MiB; no clearing pass, the first command may follow reset.
// Receiver stall: the output register holds its word; the back stops popping
// and the queue fills, after which s_axis_tready drops.
`default_nettype none

module flash_write_aligner_unit #(
  parameter int unsigned BLOCK_BYTES = fwa_pkg::BLOCK_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH = fwa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // tdata: data_byte[7:0], byte_address[39:8], range_start[71:40], range_end[103:72]
  input  logic [fwa_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // tuser: opcode[1:0]
  input  logic [1:0]                       s_axis_tuser,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: write_address[31:0], block_data[95:32], status[97:96], overlaps[98], zero[103:99]
  output logic [fwa_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // tuser: is_block_write[0]
  output logic                             m_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic                             cfg_we_i,
  input  logic [31:0]                      cfg_wdata_i
);
  import fwa_pkg::*;

  logic [31:0] flash_size_q;
  logic        q_push, q_pop, q_empty, q_full;
  cmd_t        front_cmd, back_cmd;
  logic [31:0] write_address;
  logic [63:0] block_data;
  logic [1:0]  status;
  logic        overlaps;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flash_size_q <= FLASH_SIZE_RST;
    end else if (cfg_we_i) begin
      flash_size_q <= cfg_wdata_i;
    end
  end

  fwa_front #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_front (
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .opcode_i       (s_axis_tuser),
    .data_byte_i    (s_axis_tdata[7:0]),
    .byte_address_i (s_axis_tdata[39:8]),
    .range_start_i  (s_axis_tdata[71:40]),
    .range_end_i    (s_axis_tdata[103:72]),
    .flash_size_i   (flash_size_q),
    .full_i         (q_full),
    .push_o         (q_push),
    .cmd_o          (front_cmd)
  );

  fwa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (front_cmd),
    .pop_i   (q_pop),
    .cmd_o   (back_cmd),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  fwa_back #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (!q_empty),
    .cmd_i            (back_cmd),
    .pop_o            (q_pop),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .is_block_write_o (m_axis_tuser),
    .write_address_o  (write_address),
    .block_data_o     (block_data),
    .status_o         (status),
    .overlaps_o       (overlaps)
  );

  assign m_axis_tdata = {5'b0, overlaps, status, block_data, write_address};

endmodule

`default_nettype wire

>>> sim/fwa_checker.sv
`timescale 1ns / 100ps
// Checker for the flash write aligner: mirrors the gather state, predicts output words, compares.
module fwa_checker
  import fwa_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [1:0]             s_axis_tuser,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   m_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic                   cfg_we_i,
  input  logic [31:0]            cfg_wdata_i,
  output int unsigned            fail_cnt_o,
  output int unsigned            pending_o
);

  localparam int unsigned BLK = BLOCK_BYTES_DEF;

  typedef struct packed {
    logic        blk;
    logic [31:0] addr;
    logic [63:0] data;
    status_e     st;
    logic        ov;
  } aligner_word_t;

  logic [7:0]    gather_q [8];
  int unsigned   fill;
  logic [31:0]   end_addr;
  logic          end_known;
  logic [31:0]   flash_size;
  aligner_word_t expected_words[$];
  int unsigned   n_fail = 0;

  assign fail_cnt_o = n_fail;

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    n_fail++;
  endtask

  function automatic logic [63:0] pack_gathered();
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < BLK && i < 8; i++)
      if (i < fill) v[8*i +: 8] = gather_q[i];
    return v;
  endfunction

  task automatic expect_word(logic blk, logic [31:0] addr, logic [63:0] data, status_e st,
                             logic ov);
    aligner_word_t w;
    w.blk  = blk;
    w.addr = addr;
    w.data = data;
    w.st   = st;
    w.ov   = ov;
    expected_words.push_back(w);
  endtask

  // one accepted command against the mirrored gather state
  task automatic predict_command(opcode_e op, logic [7:0] b, logic [31:0] a,
                                 logic [31:0] rs, logic [31:0] re);
    logic cont;
    case (op)
      OP_WRITE: begin
        if (fill > 0 && (!end_known || a != end_addr)) begin
          expect_word(1'b0, '0, '0, ST_NOT_CONTIG, 1'b0);
          return;
        end
        if (fill == 0) begin
          cont = end_known && (a == end_addr);
          if (!cont && (a % BLK) != 0) begin
            expect_word(1'b0, '0, '0, ST_MISALIGNED, 1'b0);
            return;
          end
          if ({32'd0, a} + 64'(BLK) > {32'd0, flash_size}) begin
            expect_word(1'b0, '0, '0, ST_BEYOND, 1'b0);
            return;
          end
        end
        if (fill < 8) gather_q[fill] = b;
        fill++;
        end_addr  = a + 32'd1;
        end_known = 1'b1;
        if (fill >= BLK) begin
          expect_word(1'b1, end_addr - 32'(fill), pack_gathered(), ST_OK, 1'b0);
          fill = 0;
        end
      end
      OP_FLUSH: begin
        if (fill > 0) begin
          expect_word(1'b1, end_addr - 32'(fill), pack_gathered(), ST_OK, 1'b0);
          fill      = 0;
          end_known = 1'b0;
        end
      end
      OP_QUERY: begin
        expect_word(1'b0, '0, '0, ST_OK,
                    fill > 0 && rs < end_addr && re > end_addr - 32'(fill));
      end
      default: ;
    endcase
  endtask

  task automatic check_word();
    aligner_word_t want;
    if (expected_words.size() == 0) begin
      report("unexpected word", {31'd0, m_axis_tuser, m_axis_tdata[31:0]}, '0);
      return;
    end
    want = expected_words[0];
    expected_words.delete(0);
    if (m_axis_tuser !== want.blk) report("is_block_write", 64'(m_axis_tuser), 64'(want.blk));
    if (m_axis_tdata[31:0] !== want.addr)
      report("write_address", 64'(m_axis_tdata[31:0]), 64'(want.addr));
    if (m_axis_tdata[95:32] !== want.data) report("block_data", m_axis_tdata[95:32], want.data);
    if (m_axis_tdata[97:96] !== want.st)
      report("status", 64'(m_axis_tdata[97:96]), 64'(want.st));
    if (m_axis_tdata[98] !== want.ov) report("overlaps", 64'(m_axis_tdata[98]), 64'(want.ov));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flash_size = FLASH_SIZE_RST;
      fill       = 0;
      end_addr   = '0;
      end_known  = 1'b0;
      expected_words.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_word();
      if (cfg_we_i) flash_size = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready)
        predict_command(opcode_e'(s_axis_tuser), s_axis_tdata[7:0], s_axis_tdata[39:8],
                        s_axis_tdata[71:40], s_axis_tdata[103:72]);
    end
    pending_o = expected_words.size();
  end

endmodule

>>> sim/tb_flash_write_aligner_unit.sv
`timescale 1ns / 100ps
// Testbench top for the flash write aligner: clock, reset, command stimulus and verdict.
module tb_flash_write_aligner_unit;
  import fwa_pkg::*;

  localparam int unsigned BLK         = BLOCK_BYTES_DEF;
  localparam int unsigned PHASE_WORDS = 90;   // five random phases, about 450 words
  localparam int unsigned HOLD_CYCLES = 60;   // long receiver hold-off to back up the queue
  localparam int unsigned DRAIN_WAIT  = 8;    // drain time for the 2-entry queue and the output register

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_e;

  logic                   clk_i;
  logic                   rst_ni;
  // tdata: data_byte[7:0], byte_address[39:8], range_start[71:40], range_end[103:72]
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  // tuser: opcode[1:0]
  logic [1:0]             s_axis_tuser;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // tdata: write_address[31:0], block_data[95:32], status[97:96], overlaps[98]
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // tuser: is_block_write[0]
  logic                   m_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic                   cfg_we_i;
  logic [31:0]            cfg_wdata_i;

  int unsigned fails;
  int unsigned pending;

  // sender bookkeeping
  int unsigned burst_left;
  int unsigned words_sent;
  logic [31:0] flash_size_now;
  logic [31:0] cursor;        // next address of the run being generated
  bit          hold_req = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  flash_write_aligner_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  fwa_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_cnt_o   (fails),
    .pending_o    (pending)
  );

  // Offer one word at the falling edge and hold it until the handshake edge.
  // tvalid stays up inside a burst; between bursts it drops for a random gap
  // with junk on the bus, which the block has to ignore.
  task automatic send_word(opcode_e op, logic [7:0] b, logic [31:0] a,
                           logic [31:0] rs, logic [31:0] re);
    s_axis_tdata  = {re, rs, a, b};
    s_axis_tuser  = op;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    if (op != OP_NONE) words_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = {$urandom, $urandom, $urandom, 8'($urandom)};
      s_axis_tuser  = 2'($urandom);
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      // mostly short bursts, now and then a long gapless stretch
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
  endtask

  // Flash size may change only with the block drained: no word pending and
  // enough cycles for commands that give no word to leave the pipeline.
  task automatic write_flash_size(logic [31:0] v);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = $urandom;
    flash_size_now = v;
  endtask

  // Aligned block start: anywhere in 32 bits, hugging the flash end, or in or just past the flash.
  function automatic logic [31:0] pick_base();
    case ($urandom_range(0, 5))
      0:       return ($urandom / BLK) * BLK;
      1:       return ((flash_size_now / BLK) + 1 - $urandom_range(0, 3)) * BLK;
      default: return $urandom_range(0, flash_size_now / BLK + 2) * BLK;
    endcase
  endfunction

  // overlap query around an address, both edges of the window get exercised
  task automatic query_near(logic [31:0] at);
    logic [31:0] rs;
    rs = at - $urandom_range(0, 2 * BLK);
    send_word(OP_QUERY, 8'($urandom), $urandom, rs, rs + $urandom_range(0, 2 * BLK));
  endtask

  // contiguous byte run from the cursor, with the odd query in between
  task automatic write_run(int unsigned n);
    repeat (n) begin
      send_word(OP_WRITE, 8'($urandom), cursor, $urandom, $urandom);
      cursor++;
      if ($urandom_range(0, 7) == 0) query_near(cursor);
    end
  endtask

  task automatic run_phase(int unsigned quota);
    int unsigned goal;
    goal = words_sent + quota;
    while (words_sent < goal) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          // well-formed run; a third of the time it continues the last one
          if ($urandom_range(0, 2) != 0) cursor = pick_base();
          write_run($urandom_range(1, 3 * BLK));
          if ($urandom_range(0, 1) != 0)
            send_word(OP_FLUSH, 8'($urandom), $urandom, $urandom, $urandom);
        end
        6: send_word(OP_QUERY, 8'($urandom), $urandom, $urandom, $urandom);
        7: begin
          // broken run: skip ahead or step back
          if ($urandom_range(0, 1) != 0)
            send_word(OP_WRITE, 8'($urandom), cursor + $urandom_range(1, BLK), $urandom,
                      $urandom);
          else
            send_word(OP_WRITE, 8'($urandom), cursor - 1, $urandom, $urandom);
        end
        8: send_word(opcode_e'($urandom_range(0, 3)), 8'($urandom), $urandom, $urandom,
                     $urandom);
        default: begin
          query_near(cursor);
          send_word(OP_FLUSH, 8'($urandom), $urandom, $urandom, $urandom);
        end
      endcase
    end
  endtask

  // Receiver: random stretches of always-ready, coin-flip, sparse and toggling
  // tready; on request one long hold-off so the queue fills and s_axis stalls.
  initial begin : rx_pattern
    rx_mode_e    mode;
    int unsigned stretch;
    m_axis_tready = 1'b0;
    forever begin
      mode    = rx_mode_e'($urandom_range(0, 3));
      stretch = $urandom_range(10, 60);
      repeat (stretch) begin
        @(negedge clk_i);
        if (hold_req) begin
          m_axis_tready = 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk_i);
          hold_req = 1'b0;
        end
        case (mode)
          RX_OPEN:   m_axis_tready = 1'b1;
          RX_COIN:   m_axis_tready = 1'($urandom_range(0, 1));
          RX_SPARSE: m_axis_tready = ($urandom_range(0, 3) == 0);
          default:   m_axis_tready = ~m_axis_tready;
        endcase
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = OP_NONE;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    burst_left     = 4;
    words_sent     = 0;
    cursor         = '0;
    flash_size_now = FLASH_SIZE_RST;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part, flash size at its reset value
    send_word(OP_QUERY, 8'h00, 32'h0, 32'h0, 32'hFFFF_FFFF);     // nothing gathered yet
    send_word(OP_WRITE, 8'hA5, 32'h3, 32'h0, 32'h0);             // unaligned start
    send_word(OP_FLUSH, 8'h00, 32'h0, 32'h0, 32'h0);             // flush with empty block
    send_word(OP_NONE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_WRITE, 8'h00, 32'h10, 32'h0, 32'h0);
    send_word(OP_WRITE, 8'hFF, 32'h11, 32'h0, 32'h0);
    send_word(OP_WRITE, 8'h5A, 32'h12, 32'h0, 32'h0);
    send_word(OP_WRITE, 8'h77, 32'h20, 32'h0, 32'h0);            // gap inside partial block
    send_word(OP_QUERY, 8'h00, 32'h0, 32'h11, 32'h12);           // hits gathered bytes
    send_word(OP_QUERY, 8'h00, 32'h0, 32'h13, 32'h40);           // starts at end address
    send_word(OP_QUERY, 8'h00, 32'h0, 32'h0, 32'h10);            // ends at block start
    send_word(OP_FLUSH, 8'h00, 32'h0, 32'h0, 32'h0);             // zero-padded block
    send_word(OP_WRITE, 8'h3C, 32'h13, 32'h0, 32'h0);            // tracking was forgotten
    cursor = 32'h100;
    write_run(BLK);                                              // one full block
    send_word(OP_WRITE, 8'hC3, FLASH_SIZE_RST - BLK, 32'h0, 32'h0); // last block that fits
    send_word(OP_FLUSH, 8'h00, 32'h0, 32'h0, 32'h0);
    send_word(OP_WRITE, 8'h81, FLASH_SIZE_RST, 32'h0, 32'h0);     // past the flash

    // random phases, flash size from none at all to the whole address space
    write_flash_size(32'h0);
    run_phase(PHASE_WORDS);
    write_flash_size(32'd64);
    run_phase(PHASE_WORDS);
    write_flash_size(32'hFFFF_FFFF);
    hold_req   = 1'b1;
    burst_left = 64;
    run_phase(PHASE_WORDS);
    write_flash_size($urandom);
    run_phase(PHASE_WORDS);
    write_flash_size(32'h0001_0000 + $urandom_range(0, 7));
    run_phase(PHASE_WORDS);

    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (2 * DRAIN_WAIT) @(negedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
